// ===== rtl/ppom_pkg.sv =====
package ppom_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 16;
  localparam int DIM_W   = 13;
  localparam int ORI_W   = 3;
  localparam int IDX_W   = 24;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int PROD_W  = IDX_W + DIM_W;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [ORI_W-1:0] ORI_IDENT        = 3'd0;
  localparam logic [ORI_W-1:0] ORI_FLIP_POS     = 3'd1;
  localparam logic [ORI_W-1:0] ORI_FLIP_REC     = 3'd2;
  localparam logic [ORI_W-1:0] ORI_ROT180       = 3'd3;
  localparam logic [ORI_W-1:0] ORI_TRANS        = 3'd4;
  localparam logic [ORI_W-1:0] ORI_TRANS_FLIP_R = 3'd5;
  localparam logic [ORI_W-1:0] ORI_TRANS_FLIP_K = 3'd6;
  localparam logic [ORI_W-1:0] ORI_ANTI_TRANS   = 3'd7;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4096);
  localparam logic [PIX_W-1:0] MIN_RESET = '1;

  typedef struct packed {
    logic             sixteen;
    logic [ORI_W-1:0] orient;
    logic [DIM_W-1:0] rlen;
    logic [DIM_W-1:0] nrec;
  } dims_t;

  typedef struct packed {
    logic [CNT_W-1:0] rec;
    logic [CNT_W-1:0] pos;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] min;
    logic [PIX_W-1:0] max;
    logic             last;
  } pix_beat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ppom_front.sv =====
module ppom_front import ppom_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dims_t             dims,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              strip_start,
  input  logic              frame_start,
  output logic              q_push,
  output pix_beat_t         q_beat,
  input  logic              q_full
);

  logic [1:0]        phase_r, phase_nxt, phase_v;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]  rec_r, rec_nxt, rec_v;
  logic [CNT_W-1:0]  pos_r, pos_nxt, pos_v;
  logic [PIX_W-1:0]  min_r, min_nxt, min_v, min_new;
  logic [PIX_W-1:0]  max_r, max_nxt, max_v, max_new;
  logic [PIX_W-1:0]  pix;
  logic              have, acc, pos_wrap, rec_wrap;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_v = (frame_start || strip_start) ? PH_FIRST : phase_r;
    rec_v   = frame_start ? '0 : rec_r;
    pos_v   = frame_start ? '0 : pos_r;
    min_v   = frame_start ? MIN_RESET : min_r;
    max_v   = frame_start ? '0 : max_r;

    phase_nxt = phase_v;
    held_nxt  = held_r;
    have      = 1'b0;
    pix       = '0;
    if (dims.sixteen) begin
      if (phase_v == PH_SECOND) begin
        pix       = {data_byte, held_r};
        have      = 1'b1;
        phase_nxt = PH_FIRST;
      end else begin
        held_nxt  = data_byte;
        phase_nxt = PH_SECOND;
      end
    end else begin
      case (phase_v)
        PH_FIRST: begin
          held_nxt  = data_byte;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          pix       = {4'b0, held_r, data_byte[7:4]};
          have      = 1'b1;
          held_nxt  = data_byte;
          phase_nxt = PH_THIRD;
        end
        default: begin
          pix       = {4'b0, held_r[3:0], data_byte};
          have      = 1'b1;
          phase_nxt = PH_FIRST;
        end
      endcase
    end

    min_new  = (pix < min_v) ? pix : min_v;
    max_new  = (pix > max_v) ? pix : max_v;
    pos_wrap = (IDX_W'(pos_v) + IDX_W'(1)) >= IDX_W'(dims.rlen);
    rec_wrap = (IDX_W'(rec_v) + IDX_W'(1)) >= IDX_W'(dims.nrec);

    min_nxt = min_v;
    max_nxt = max_v;
    pos_nxt = pos_v;
    rec_nxt = rec_v;
    if (have) begin
      min_nxt = min_new;
      max_nxt = max_new;
      if (pos_wrap) begin
        pos_nxt = '0;
        rec_nxt = rec_wrap ? '0 : CNT_W'(rec_v + 1'b1);
      end else begin
        pos_nxt = CNT_W'(pos_v + 1'b1);
      end
    end
  end

  assign q_push      = acc && have;
  assign q_beat.rec  = rec_v;
  assign q_beat.pos  = pos_v;
  assign q_beat.pix  = pix;
  assign q_beat.min  = min_new;
  assign q_beat.max  = max_new;
  assign q_beat.last = pos_wrap && rec_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held_r  <= '0;
      rec_r   <= '0;
      pos_r   <= '0;
      min_r   <= MIN_RESET;
      max_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      rec_r   <= rec_nxt;
      pos_r   <= pos_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

// ===== rtl/ppom_fifo.sv =====
module ppom_fifo import ppom_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pix_beat_t push_beat,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pix_beat_t head_beat
);

  pix_beat_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push_ok, pop_ok;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_beat  = mem_r[rd_r];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= QPTR_W'(wr_r + 1'b1);
      end
      if (pop_ok) begin
        rd_r <= QPTR_W'(rd_r + 1'b1);
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= (QPTR_W+1)'(cnt_r + 1'b1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= (QPTR_W+1)'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/ppom_back.sv =====
module ppom_back import ppom_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dims_t            dims,
  input  logic             head_valid,
  input  pix_beat_t        head_beat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_dest_index,
  output logic [PIX_W-1:0] out_pixel_value,
  output logic [PIX_W-1:0] out_running_min,
  output logic [PIX_W-1:0] out_running_max,
  output logic             out_frame_last
);

  logic [IDX_W-1:0]  ir, k, rr, nn, op_a, op_add;
  logic [DIM_W-1:0]  op_b;
  logic              s1_en, s2_en;
  logic [PROD_W-1:0] prod;

  logic              s1_v_r;
  logic [IDX_W-1:0]  s1_a_r, s1_add_r;
  logic [DIM_W-1:0]  s1_b_r;
  logic [PIX_W-1:0]  s1_pix_r, s1_min_r, s1_max_r;
  logic              s1_last_r;

  logic              s2_v_r;
  logic [IDX_W-1:0]  s2_idx_r;
  logic [PIX_W-1:0]  s2_pix_r, s2_min_r, s2_max_r;
  logic              s2_last_r;

  always_comb begin
    ir = IDX_W'(head_beat.rec);
    k  = IDX_W'(head_beat.pos);
    rr = IDX_W'(dims.rlen);
    nn = IDX_W'(dims.nrec);
    op_b = dims.orient[2] ? dims.nrec : dims.rlen;
    case (dims.orient)
      ORI_IDENT: begin
        op_a = ir;           op_add = k;
      end
      ORI_FLIP_POS: begin
        op_a = ir + 1'b1;    op_add = ~k;
      end
      ORI_FLIP_REC: begin
        op_a = nn - 1'b1 - ir; op_add = k;
      end
      ORI_ROT180: begin
        op_a = nn - ir;      op_add = ~k;
      end
      ORI_TRANS: begin
        op_a = k;            op_add = ir;
      end
      ORI_TRANS_FLIP_R: begin
        op_a = k;            op_add = nn - 1'b1 - ir;
      end
      ORI_TRANS_FLIP_K: begin
        op_a = rr - 1'b1 - k; op_add = ir;
      end
      ORI_ANTI_TRANS: begin
        op_a = rr - 1'b1 - k; op_add = nn - 1'b1 - ir;
      end
      default: begin
        op_a = '0;           op_add = '0;
      end
    endcase
  end

  assign s2_en = !s2_v_r || out_ready;
  assign s1_en = !s1_v_r || s2_en;
  assign pop   = head_valid && s1_en;
  assign prod  = s1_a_r * s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= head_valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && head_valid) begin
      s1_a_r    <= op_a;
      s1_b_r    <= op_b;
      s1_add_r  <= op_add;
      s1_pix_r  <= head_beat.pix;
      s1_min_r  <= head_beat.min;
      s1_max_r  <= head_beat.max;
      s1_last_r <= head_beat.last;
    end
    if (s2_en && s1_v_r) begin
      s2_idx_r  <= prod[IDX_W-1:0] + s1_add_r;
      s2_pix_r  <= s1_pix_r;
      s2_min_r  <= s1_min_r;
      s2_max_r  <= s1_max_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_valid       = s2_v_r;
  assign out_dest_index  = s2_idx_r;
  assign out_pixel_value = s2_pix_r;
  assign out_running_min = s2_min_r;
  assign out_running_max = s2_max_r;
  assign out_frame_last  = s2_last_r;

endmodule

// ===== rtl/packed_pixel_orient_minmax.sv =====
// Raw image byte stream in, reoriented pixels out.
// Input channel (in_*): one byte per beat with strip_start / frame_start
// flags. In 12-bit mode three bytes give two pixels, in 16-bit mode two
// bytes give one little-endian pixel. Bytes that complete no pixel give
// no output beat.
// Output channel (out_*): one beat per pixel with its destination index in
// the selected orientation, the pixel, the running min/max of the frame and
// a mark on the final pixel of the frame.
// Config (cfg_*): single-cycle writes, index 0 mode, 1 orientation,
// 2 width, 3 height. Write only while no beats are in flight.
// Throughput: one byte per clock while in_ready is high. The path from the
// byte that completes a pixel to the output beat is a 4-entry beat queue,
// an operand stage and a multiply/add stage that is the output register.
// Reset: sync, active low; clears queue and pipeline, counters, byte phase,
// min/max, and loads the config defaults (12-bit, identity, 4096 x 4096).
// Output stall: the output register holds; the queue then fills and
// in_ready drops once it holds four pixels.
module packed_pixel_orient_minmax import ppom_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_strip_start,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_dest_index,
  output logic [PIX_W-1:0]     out_pixel_value,
  output logic [PIX_W-1:0]     out_running_min,
  output logic [PIX_W-1:0]     out_running_max,
  output logic                 out_frame_last
);

  logic             sixteen_r;
  logic [ORI_W-1:0] orient_r;
  logic [DIM_W-1:0] width_r, height_r, w_eff, h_eff;
  dims_t            dims;

  logic      q_push, q_full, q_valid, q_pop;
  pix_beat_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sixteen_r <= 1'b0;
      orient_r  <= ORI_IDENT;
      width_r   <= DIM_RESET;
      height_r  <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:   sixteen_r <= cfg_wdata[0];
        REG_ORIENT: orient_r  <= cfg_wdata[ORI_W-1:0];
        REG_WIDTH:  width_r   <= cfg_wdata;
        REG_HEIGHT: height_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign w_eff        = clamp_dim(width_r, MAX_WIDTH);
  assign h_eff        = clamp_dim(height_r, MAX_HEIGHT);
  assign dims.sixteen = sixteen_r;
  assign dims.orient  = orient_r;
  assign dims.rlen    = orient_r[2] ? w_eff : h_eff;
  assign dims.nrec    = orient_r[2] ? h_eff : w_eff;

  ppom_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (in_data_byte),
    .strip_start (in_strip_start),
    .frame_start (in_frame_start),
    .q_push      (q_push),
    .q_beat      (q_in),
    .q_full      (q_full)
  );

  ppom_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_beat  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_beat  (q_head)
  );

  ppom_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dims            (dims),
    .head_valid      (q_valid),
    .head_beat       (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dest_index  (out_dest_index),
    .out_pixel_value (out_pixel_value),
    .out_running_min (out_running_min),
    .out_running_max (out_running_max),
    .out_frame_last  (out_frame_last)
  );

  a_minmax_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_running_min <= out_pixel_value) &&
                  (out_pixel_value <= out_running_max))
    else $error("pixel outside running min/max");

  a_twelve_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sixteen_r |-> out_pixel_value[PIX_W-1:12] == '0)
    else $error("12-bit pixel has upper bits set");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_queue_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !q_full |-> in_ready)
    else $error("input stalled with queue space");

endmodule
